// File: rtl/sbcd_pkg.sv
// Shared types and constants for the strided block copy DMA sequencer.
`default_nettype none
package sbcd_pkg;

	localparam int AddrWidthDef = 32;
	localparam int AddrWidthMax = 64;
	localparam int RegIdxWidth  = 3;

	// value of control_value that arms a block
	localparam logic [31:0] StartCmd = 32'd1;

	typedef enum logic {
		OpStart   = 1'b0,
		OpAdvance = 1'b1
	} op_t;

	typedef enum logic [RegIdxWidth-1:0] {
		RegSourceBase  = 3'd0,
		RegDestBase    = 3'd1,
		RegRowBytes    = 3'd2,
		RegRowTotal    = 3'd3,
		RegSourcePitch = 3'd4,
		RegDestPitch   = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] source_base;
		logic [31:0] dest_base;
		logic [31:0] row_bytes;
		logic [31:0] row_total;
		logic [31:0] source_pitch;
		logic [31:0] dest_pitch;
	} cfg_t;

	// first pipeline stage: everything but the byte count product
	typedef struct packed {
		logic        valid;
		logic        issue;
		logic [31:0] read_address;
		logic [31:0] write_address;
		logic [31:0] mul_a;
		logic [31:0] mul_b;
		logic        last;
	} stage1_t;

endpackage
`default_nettype wire

// File: rtl/strided_block_copy_dma_core.sv
// Top level of the strided block copy DMA address sequencer.
// Usage: program the six registers over the cfg channel (cfg_index 0..5:
// source base, dest base, row bytes, row total, source pitch, dest pitch);
// cfg_ready is always high and indexes 6 and 7 are dropped. On the input
// channel, opcode start with control_value 1 arms a block while idle, and
// each advance transfer produces the next row's read/write addresses.
// Every input transfer yields exactly one output transfer; when nothing is
// issued all output fields are zero. Equal pitches and row width collapse
// the block into one transfer of row_bytes * rows bytes, marked last.
// Pipeline: the sequencer stage registers each accepted input, then the count
// multiply stage registers it into the output transfer.
// Throughput: one item per cycle while out_stall is low, set by the row counter
// and address accumulators; the 32x32 byte count multiply has its own stage.
// Reset clears the registers and the block state to idle, and both
// pipeline stages to empty. When out_stall is high the output register
// holds; the stage in front fills, then in_stall rises.
`default_nettype none
module strided_block_copy_dma_core #(
	parameter int ADDR_WIDTH = sbcd_pkg::AddrWidthDef
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [sbcd_pkg::RegIdxWidth-1:0]  cfg_index,
	input  wire logic [31:0]                       cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              opcode,
	input  wire logic [31:0]                       control_value,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   issue,
	output logic [31:0]                            read_address,
	output logic [31:0]                            write_address,
	output logic [31:0]                            byte_count,
	output logic                                   last
);
	import sbcd_pkg::*;

	cfg_t    cfg;
	stage1_t s1;
	logic    s2_ready;

	sbcd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sbcd_seq #(
		.ADDR_WIDTH (ADDR_WIDTH)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.control_value (control_value),
		.s2_ready      (s2_ready),
		.s1            (s1)
	);

	sbcd_count u_count (
		.clk           (clk),
		.arst_n        (arst_n),
		.s1            (s1),
		.s2_ready      (s2_ready),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.issue         (issue),
		.read_address  (read_address),
		.write_address (write_address),
		.byte_count    (byte_count),
		.last          (last)
	);

endmodule
`default_nettype wire

// File: rtl/sbcd_cfg_regs.sv
// Configuration register file of the strided block copy DMA sequencer.
`default_nettype none
module sbcd_cfg_regs (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [sbcd_pkg::RegIdxWidth-1:0]    cfg_index,
	input  wire logic [31:0]                         cfg_data,
	output sbcd_pkg::cfg_t                           cfg
);
	import sbcd_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				RegSourceBase:  cfg_q.source_base  <= cfg_data;
				RegDestBase:    cfg_q.dest_base    <= cfg_data;
				RegRowBytes:    cfg_q.row_bytes    <= cfg_data;
				RegRowTotal:    cfg_q.row_total    <= cfg_data;
				RegSourcePitch: cfg_q.source_pitch <= cfg_data;
				RegDestPitch:   cfg_q.dest_pitch   <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/sbcd_seq.sv
// Row sequencer: block state, address accumulators and the first pipeline stage.
`default_nettype none
module sbcd_seq #(
	parameter int ADDR_WIDTH = sbcd_pkg::AddrWidthDef
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  sbcd_pkg::cfg_t         cfg,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              opcode,
	input  wire logic [31:0]       control_value,
	input  wire logic              s2_ready,
	output sbcd_pkg::stage1_t      s1
);
	import sbcd_pkg::*;

	logic                  busy_q;
	logic [31:0]           row_index_q;
	logic [ADDR_WIDTH-1:0] src_row_q;
	logic [ADDR_WIDTH-1:0] dst_row_q;
	stage1_t               s1_q;

	logic                  accept;
	logic                  contig;
	logic                  is_adv;
	logic                  rows_left;
	logic                  fin;
	logic                  do_issue;
	logic [31:0]           rows_rem;
	logic [31:0]           src_out;
	logic [31:0]           dst_out;

	assign in_stall  = s1_q.valid && !s2_ready;
	assign accept    = in_valid && !in_stall;
	assign is_adv    = (opcode == OpAdvance);
	assign contig    = (cfg.source_pitch == cfg.row_bytes) && (cfg.dest_pitch == cfg.row_bytes);
	assign rows_left = (row_index_q < cfg.row_total);
	assign fin       = (row_index_q + 32'd1 == cfg.row_total);
	assign do_issue  = is_adv && busy_q && (contig || rows_left);
	assign rows_rem  = rows_left ? (cfg.row_total - row_index_q) : '0;
	assign src_out   = 32'(AddrWidthMax'(src_row_q));
	assign dst_out   = 32'(AddrWidthMax'(dst_row_q));
	assign s1        = s1_q;

	// block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			row_index_q <= '0;
			src_row_q   <= '0;
			dst_row_q   <= '0;
		end else if (accept) begin
			if (!is_adv) begin
				if (control_value == StartCmd && !busy_q) begin
					row_index_q <= '0;
					src_row_q   <= ADDR_WIDTH'(cfg.source_base);
					dst_row_q   <= ADDR_WIDTH'(cfg.dest_base);
					busy_q      <= contig || (cfg.row_total != '0);
				end
			end else if (busy_q) begin
				if (contig || !rows_left) begin
					busy_q <= 1'b0;
				end else begin
					row_index_q <= row_index_q + 32'd1;
					src_row_q   <= src_row_q + ADDR_WIDTH'(cfg.source_pitch);
					dst_row_q   <= dst_row_q + ADDR_WIDTH'(cfg.dest_pitch);
					if (fin) begin
						busy_q <= 1'b0;
					end
				end
			end
		end
	end

	// stage 1 register; a result that issues nothing carries zeros in every field but valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_q <= '0;
		end else if (accept) begin
			s1_q.valid         <= 1'b1;
			s1_q.issue         <= do_issue;
			s1_q.read_address  <= do_issue ? src_out : '0;
			s1_q.write_address <= do_issue ? dst_out : '0;
			s1_q.mul_a         <= do_issue ? cfg.row_bytes : '0;
			s1_q.mul_b         <= !do_issue ? '0 : (contig ? rows_rem : 32'd1);
			s1_q.last          <= do_issue && (contig || fin);
		end else if (s2_ready) begin
			s1_q.valid <= 1'b0;
		end
	end

	a_busy_falls_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> $past(accept && is_adv))
		else $error("busy dropped without an accepted advance");

	a_start_clears_row: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !is_adv && control_value == StartCmd && !busy_q |=> row_index_q == '0)
		else $error("start did not rewind the row index");

	a_idle_advance_silent: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_adv && !busy_q |=> !s1_q.issue)
		else $error("advance while idle issued a transfer");

endmodule
`default_nettype wire

// File: rtl/sbcd_count.sv
// Byte count multiply and output register of the strided block copy DMA sequencer.
`default_nettype none
module sbcd_count (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  sbcd_pkg::stage1_t      s1,
	output logic                   s2_ready,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   issue,
	output logic [31:0]            read_address,
	output logic [31:0]            write_address,
	output logic [31:0]            byte_count,
	output logic                   last
);
	import sbcd_pkg::*;

	logic        valid_s2;
	logic        issue_s2;
	logic [31:0] rd_s2;
	logic [31:0] wr_s2;
	logic [31:0] count_s2;
	logic        last_s2;

	assign s2_ready = !valid_s2 || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= s1.valid;
		end
	end

	// low 32 bits of the product give the count modulo 2^32
	always_ff @(posedge clk) begin
		if (s2_ready && s1.valid) begin
			issue_s2 <= s1.issue;
			rd_s2    <= s1.read_address;
			wr_s2    <= s1.write_address;
			count_s2 <= s1.mul_a * s1.mul_b;
			last_s2  <= s1.last;
		end
	end

	assign out_valid     = valid_s2;
	assign issue         = issue_s2;
	assign read_address  = rd_s2;
	assign write_address = wr_s2;
	assign byte_count    = count_s2;
	assign last          = last_s2;

	a_last_needs_issue: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && last_s2 |-> issue_s2)
		else $error("last flagged on a result that issues nothing");

endmodule
`default_nettype wire
